>>> src/atan2li_pkg.sv
// atan2li_pkg: widths, control struct and arctangent table for the atan2 block
// no dependencies; the table is computed at elaboration with integer math only
`default_nettype none

package atan2li_pkg;

    // number formats
    localparam int TABLE_SEGMENTS  = 100;
    localparam int RATIO_FRAC_BITS = 15;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int GUARD_BITS      = 8;
    localparam int ROM_FRAC        = ANGLE_FRAC_BITS + GUARD_BITS;

    localparam int IN_W   = 16;
    localparam int MAG_W  = IN_W;                     // |-32768| still fits unsigned
    localparam int REM_W  = MAG_W + 1;
    localparam int Q_W    = RATIO_FRAC_BITS + 1;      // ratio in 0..1 inclusive
    localparam int IDX_W  = $clog2(TABLE_SEGMENTS + 1);
    localparam int POS_W  = Q_W + IDX_W;
    localparam int ROM_W  = ROM_FRAC + 6;             // up to 45 degrees
    localparam int PROD_W = ROM_W + RATIO_FRAC_BITS;
    localparam int V_W    = ROM_FRAC + 9;             // up to 360 degrees
    localparam int OUT_W  = ANGLE_FRAC_BITS + 9;

    // divider: quotient bits resolved per stage
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (Q_W + DIV_STEP - 1) / DIV_STEP;

    localparam int INTERP_STAGES = 4;

    localparam logic [V_W-1:0] D90  = V_W'(90) << ROM_FRAC;
    localparam logic [V_W-1:0] D180 = V_W'(180) << ROM_FRAC;
    localparam logic [V_W-1:0] D270 = V_W'(270) << ROM_FRAC;
    localparam logic [V_W-1:0] D360 = V_W'(360) << ROM_FRAC;
    localparam logic [V_W-1:0] ROUND_HALF = V_W'(1) << (GUARD_BITS - 1);

    typedef struct packed {
        logic swap;     // |y| > |x|, ratio taken as |x|/|y|
        logic xzero;
        logic yzero;
        logic xneg;
        logic yneg;
    } t_ctl;

    typedef logic [ROM_W-1:0] t_rom [0:TABLE_SEGMENTS];

    // restoring long division, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // floor(a * m / d) without overflowing the product
    function automatic logic [63:0] mul_div(input logic [63:0] a, input logic [63:0] m,
                                            input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] rm;
        q  = udiv64(a, d);
        rm = a - q * d;
        return q * m + udiv64(rm * m, d);
    endfunction

    // atan(k/n) in radians, 56 fraction bits, series in k^2/(k^2+n^2)
    function automatic logic [63:0] atan_q56(input logic [63:0] k, input logic [63:0] n);
        logic [63:0] d;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] kk;
        if (k == 64'd0 || n == 64'd0) begin
            return 64'd0;
        end
        kk   = k * k;
        d    = kk + n * n;
        term = 64'd1 << 56;
        sum  = term;
        for (int j = 1; j < 90; j++) begin
            if (term != 64'd0) begin
                term = udiv64(term * 64'(2 * j), 64'(2 * j + 1));
                term = mul_div(term, kk, d);
                sum  = sum + term;
            end
        end
        return mul_div(sum, k * n, d);
    endfunction

    // entry k: floor(45 deg * 2^ROM_FRAC * atan(k/N)/atan(1)), ratio to 40 bits
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] full;
        logic [63:0] a;
        logic [63:0] f;
        logic [63:0] r;
        full = atan_q56(64'(TABLE_SEGMENTS), 64'(TABLE_SEGMENTS));
        for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
            a = atan_q56(64'(k), 64'(TABLE_SEGMENTS));
            f = '0;
            r = a;
            if (r >= full) begin
                f = 64'd1 << 40;
            end else begin
                for (int b = 0; b < 40; b++) begin
                    r = r << 1;
                    f = f << 1;
                    if (r >= full) begin
                        r    = r - full;
                        f[0] = 1'b1;
                    end
                end
            end
            rom[k] = ROM_W'((f * 64'd45) >> (40 - ROM_FRAC));
        end
        return rom;
    endfunction

    localparam t_rom ATAN_ROM = build_rom();

endpackage

`default_nettype wire

>>> src/atan2li_div.sv
// atan2li_div: pipelined restoring divider, quotient = (num << RATIO_FRAC_BITS) / den
// depends on atan2li_pkg; num <= den is required, control struct rides along
`default_nettype none

module atan2li_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  atan2li_pkg::t_ctl             i_ctl,
    input  logic [atan2li_pkg::MAG_W-1:0] i_num,
    input  logic [atan2li_pkg::MAG_W-1:0] i_den,
    output logic                          o_valid,
    output atan2li_pkg::t_ctl             o_ctl,
    output logic [atan2li_pkg::Q_W-1:0]   o_quo
);

    localparam int STAGES = atan2li_pkg::DIV_STAGES;
    localparam int STEP   = atan2li_pkg::DIV_STEP;
    localparam int Q_W    = atan2li_pkg::Q_W;
    localparam int REM_W  = atan2li_pkg::REM_W;
    localparam int MAG_W  = atan2li_pkg::MAG_W;

    logic [STAGES-1:0]     r_valid;
    logic [REM_W-1:0]      r_rem [0:STAGES-1];
    logic [MAG_W-1:0]      r_den [0:STAGES-1];
    logic [Q_W-1:0]        r_quo [0:STAGES-1];
    atan2li_pkg::t_ctl     r_ctl [0:STAGES-1];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic              in_valid;
        logic [REM_W-1:0]  in_rem;
        logic [MAG_W-1:0]  in_den;
        logic [Q_W-1:0]    in_quo;
        atan2li_pkg::t_ctl in_ctl;
        logic [REM_W-1:0]  n_rem;
        logic [Q_W-1:0]    n_quo;

        if (s == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_rem   = {1'b0, i_num};
            assign in_den   = i_den;
            assign in_quo   = '0;
            assign in_ctl   = i_ctl;
        end else begin : g_next
            assign in_valid = r_valid[s-1];
            assign in_rem   = r_rem[s-1];
            assign in_den   = r_den[s-1];
            assign in_quo   = r_quo[s-1];
            assign in_ctl   = r_ctl[s-1];
        end

        // compare-subtract, then shift the partial remainder for the next bit
        always_comb begin
            n_rem = in_rem;
            n_quo = in_quo;
            for (int k = 0; k < STEP; k++) begin
                if (s * STEP + k < Q_W) begin
                    if (n_rem >= {1'b0, in_den}) begin
                        n_rem = n_rem - {1'b0, in_den};
                        n_quo = {n_quo[Q_W-2:0], 1'b1};
                    end else begin
                        n_quo = {n_quo[Q_W-2:0], 1'b0};
                    end
                    n_rem = {n_rem[REM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_den[s] <= in_den;
            r_quo[s] <= n_quo;
            r_ctl[s] <= in_ctl;
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_ctl   = r_ctl[STAGES-1];
    assign o_quo   = r_quo[STAGES-1];

endmodule

`default_nettype wire

>>> src/atan2li_interp.sv
// atan2li_interp: table position, two table reads, slope multiply and sum
// depends on atan2li_pkg (ATAN_ROM table and widths); four register stages
`default_nettype none

module atan2li_interp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  atan2li_pkg::t_ctl             i_ctl,
    input  logic [atan2li_pkg::Q_W-1:0]   i_quo,
    output logic                          o_valid,
    output atan2li_pkg::t_ctl             o_ctl,
    output logic [atan2li_pkg::ROM_W-1:0] o_theta
);

    localparam int N      = atan2li_pkg::TABLE_SEGMENTS;
    localparam int RFB    = atan2li_pkg::RATIO_FRAC_BITS;
    localparam int POS_W  = atan2li_pkg::POS_W;
    localparam int IDX_W  = atan2li_pkg::IDX_W;
    localparam int ROM_W  = atan2li_pkg::ROM_W;
    localparam int PROD_W = atan2li_pkg::PROD_W;
    localparam int IPOS_W = POS_W - RFB;

    // stage 1: position
    logic [POS_W-1:0]  n_pos;
    logic [IPOS_W-1:0] n_ipos;
    logic [IDX_W-1:0]  n_idx;
    logic [IDX_W-1:0]  n_idx_hi;
    logic [RFB-1:0]    n_frac;
    logic              r_pos_valid;
    atan2li_pkg::t_ctl r_pos_ctl;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_idx_hi;
    logic [RFB-1:0]    r_pos_frac;

    // stage 2: table reads
    logic              r_rd_valid;
    atan2li_pkg::t_ctl r_rd_ctl;
    logic [ROM_W-1:0]  r_lo;
    logic [ROM_W-1:0]  r_hi;
    logic [RFB-1:0]    r_rd_frac;

    // stage 3: slope product
    logic              r_mul_valid;
    atan2li_pkg::t_ctl r_mul_ctl;
    logic [ROM_W-1:0]  r_mul_lo;
    logic [PROD_W-1:0] r_prod;

    // stage 4: sum
    logic              r_sum_valid;
    atan2li_pkg::t_ctl r_sum_ctl;
    logic [ROM_W-1:0]  r_theta;

    always_comb begin
        n_pos  = POS_W'(i_quo) * POS_W'(N);
        n_ipos = n_pos[POS_W-1:RFB];
        if (n_ipos >= IPOS_W'(N)) begin
            // ratio of exactly one sits on the last entry with zero slope
            n_idx    = IDX_W'(N);
            n_idx_hi = IDX_W'(N);
            n_frac   = '0;
        end else begin
            n_idx    = n_ipos[IDX_W-1:0];
            n_idx_hi = n_ipos[IDX_W-1:0] + 1'b1;
            n_frac   = n_pos[RFB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_mul_valid <= 1'b0;
            r_sum_valid <= 1'b0;
        end else begin
            r_pos_valid <= i_valid;
            r_rd_valid  <= r_pos_valid;
            r_mul_valid <= r_rd_valid;
            r_sum_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_ctl  <= i_ctl;
        r_idx      <= n_idx;
        r_idx_hi   <= n_idx_hi;
        r_pos_frac <= n_frac;

        r_rd_ctl   <= r_pos_ctl;
        r_lo       <= atan2li_pkg::ATAN_ROM[r_idx];
        r_hi       <= atan2li_pkg::ATAN_ROM[r_idx_hi];
        r_rd_frac  <= r_pos_frac;

        r_mul_ctl  <= r_rd_ctl;
        r_mul_lo   <= r_lo;
        r_prod     <= PROD_W'(r_hi - r_lo) * PROD_W'(r_rd_frac);

        r_sum_ctl  <= r_mul_ctl;
        r_theta    <= r_mul_lo + r_prod[PROD_W-1:RFB];
    end

    assign o_valid = r_sum_valid;
    assign o_ctl   = r_sum_ctl;
    assign o_theta = r_theta;

endmodule

`default_nettype wire

>>> src/atan2_lut_interp_degrees_top.sv
// an input goes through the input, divider, interpolator, octant, quadrant and output stages
// throughput: one transfer per cycle, fully pipelined; busy only reflects reset
// the divider and the table interpolator are 4-stage pipelines each
// reset: synchronous, active low; clears every valid bit, busy high during reset
// and after it until the registered busy flag clears; the result strobe cannot be held off
`default_nettype none

module atan2_lut_interp_degrees_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [atan2li_pkg::IN_W-1:0] i_x_value,
    input  logic signed [atan2li_pkg::IN_W-1:0] i_y_value,
    output logic                                o_strobe,
    output logic        [atan2li_pkg::OUT_W-1:0] o_angle_deg
);

    localparam int IN_W   = atan2li_pkg::IN_W;
    localparam int MAG_W  = atan2li_pkg::MAG_W;
    localparam int Q_W    = atan2li_pkg::Q_W;
    localparam int ROM_W  = atan2li_pkg::ROM_W;
    localparam int V_W    = atan2li_pkg::V_W;
    localparam int GUARD  = atan2li_pkg::GUARD_BITS;
    localparam int LATENCY = 1 + atan2li_pkg::DIV_STAGES + atan2li_pkg::INTERP_STAGES + 3;

    // accept control: nothing inside ever stalls
    logic r_busy;
    logic accept;

    assign busy   = r_busy | ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // input stage: magnitudes, octant selection, special-case flags
    logic [IN_W-1:0]   x_bits;
    logic [IN_W-1:0]   y_bits;
    logic [MAG_W-1:0]  n_ax;
    logic [MAG_W-1:0]  n_ay;
    atan2li_pkg::t_ctl n_in_ctl;
    logic              r_in_valid;
    atan2li_pkg::t_ctl r_in_ctl;
    logic [MAG_W-1:0]  r_num;
    logic [MAG_W-1:0]  r_den;

    assign x_bits = i_x_value;
    assign y_bits = i_y_value;

    always_comb begin
        // two's complement magnitude; -32768 maps to 32768
        n_ax = x_bits[IN_W-1] ? (~x_bits + 1'b1) : x_bits;
        n_ay = y_bits[IN_W-1] ? (~y_bits + 1'b1) : y_bits;
        n_in_ctl.swap  = n_ay > n_ax;
        n_in_ctl.xzero = (n_ax == '0);
        n_in_ctl.yzero = (n_ay == '0);
        n_in_ctl.xneg  = x_bits[IN_W-1];
        n_in_ctl.yneg  = y_bits[IN_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    // smaller magnitude over larger keeps the ratio within 0..1
    always_ff @(posedge i_clk) begin
        r_in_ctl <= n_in_ctl;
        r_num    <= n_in_ctl.swap ? n_ax : n_ay;
        r_den    <= n_in_ctl.swap ? n_ay : n_ax;
    end

    // ratio divider
    logic              div_valid;
    atan2li_pkg::t_ctl div_ctl;
    logic [Q_W-1:0]    div_quo;

    atan2li_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_ctl   (r_in_ctl),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_valid (div_valid),
        .o_ctl   (div_ctl),
        .o_quo   (div_quo)
    );

    // table lookup with linear interpolation, angle in [0, 45] degrees
    logic              lut_valid;
    atan2li_pkg::t_ctl lut_ctl;
    logic [ROM_W-1:0]  lut_theta;

    atan2li_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .i_ctl   (div_ctl),
        .i_quo   (div_quo),
        .o_valid (lut_valid),
        .o_ctl   (lut_ctl),
        .o_theta (lut_theta)
    );

    // octant stage: reflect about 45 degrees when the ratio was inverted
    logic              r_oct_valid;
    atan2li_pkg::t_ctl r_oct_ctl;
    logic [V_W-1:0]    r_theta_oct;

    // quadrant stage: place the first-quadrant angle around the circle, plus 180
    logic              r_quad_valid;
    logic [V_W-1:0]    n_v;
    logic [V_W-1:0]    r_v;

    // output stage: round half up to the output fraction
    logic [V_W-1:0]    n_round;
    logic              r_strobe;
    logic [V_W-GUARD-1:0] r_angle;

    always_comb begin
        if (r_oct_ctl.xzero) begin
            if (r_oct_ctl.yzero) begin
                n_v = atan2li_pkg::D180;
            end else if (r_oct_ctl.yneg) begin
                n_v = atan2li_pkg::D90;
            end else begin
                n_v = atan2li_pkg::D270;
            end
        end else if (!r_oct_ctl.xneg) begin
            if (r_oct_ctl.yzero) begin
                n_v = atan2li_pkg::D180;
            end else if (r_oct_ctl.yneg) begin
                n_v = atan2li_pkg::D180 - r_theta_oct;
            end else begin
                n_v = atan2li_pkg::D180 + r_theta_oct;
            end
        end else if (!r_oct_ctl.yneg) begin
            // second quadrant, and the negative x axis lands on 360
            n_v = atan2li_pkg::D360 - r_theta_oct;
        end else begin
            n_v = r_theta_oct;
        end
    end

    assign n_round = r_v + atan2li_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_valid  <= 1'b0;
            r_quad_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_oct_valid  <= lut_valid;
            r_quad_valid <= r_oct_valid;
            r_strobe     <= r_quad_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oct_ctl   <= lut_ctl;
        r_theta_oct <= lut_ctl.swap ? (atan2li_pkg::D90 - V_W'(lut_theta)) : V_W'(lut_theta);
        r_v         <= n_v;
        r_angle     <= n_round[V_W-1:GUARD];
    end

    assign o_strobe    = r_strobe;
    assign o_angle_deg = r_angle;

`ifndef SYNTHESIS
    // every transfer in yields exactly one strobe after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("accepted item did not produce a result on time");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("result strobe without a matching input transfer");

    // folded angle never exceeds 90 degrees: catches a bad table or divider
    a_octant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oct_valid |-> (r_theta_oct <= atan2li_pkg::D90))
        else $error("octant angle out of range");

    a_circle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_quad_valid |-> (r_v <= atan2li_pkg::D360))
        else $error("full-circle angle out of range");
`endif

endmodule

`default_nettype wire
